// ===== hdl/nucs_pkg.sv =====
// Shared types and constants for the nearest unused color search block.
package nucs_pkg;

	localparam int unsigned WORD_W   = 64;
	localparam int unsigned WORD_AW  = 6;
	localparam logic [2:0]  DEPTH_RST = 3'd6;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	// Squared difference of one channel value against the pixel.
	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return 16'(d) * 16'(d);
	endfunction

endpackage

// ===== hdl/nearest_unused_color_search_top.sv =====
// Top level of the nearest unused color search block.
//
// Usage: a pixel request arrives on s_axis (tdata = red, green, blue from
// bit 0 up). The block scans every color of the quantized cube, one entry
// per cycle, reading the availability map one 64-bit word per cycle from a
// synchronous RAM. The nearest available color (ties to the first in
// red, green, blue ascending order) is marked used in the RAM by a
// read-modify-write of its word and sent on m_axis (tdata = red, green,
// blue; tuser = exhausted, set with black data when no color is left).
// A single candidate distance unit visits every cube entry.
// One pixel is in work at a time; the next request is taken once the
// result leaves the output register.
// Reset: depth returns to 6 and a clearing pass writes all ones into the
// map with s_axis_tready low. cfg writes are taken at any time the
// block is idle.
// Stall: when m_axis_tready is low the result holds in the output
// register and no new pixel is accepted.
module nearest_unused_color_search_top #(
	parameter int unsigned MAX_DEPTH = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_red[7:0], in_green[15:8], in_blue[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic        m_axis_tuser   // exhausted[0]
);

	localparam int unsigned IDX_W = 3 * MAX_DEPTH;
	localparam int unsigned WORDS = (2 ** IDX_W + nucs_pkg::WORD_W - 1) / nucs_pkg::WORD_W;
	localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned BIT_W = (IDX_W < nucs_pkg::WORD_AW) ? IDX_W : nucs_pkg::WORD_AW;

	nucs_pkg::state_t state_q, state_d;

	logic [2:0]       depth_q;
	logic [2:0]       d_eff;
	logic [7:0]       pr_q, pg_q, pb_q;
	logic [IDX_W:0]   cnt_q;      // candidate index being issued
	logic [IDX_W:0]   total;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic             vld_s1, vld_s2;
	logic             avail_s2;
	logic [7:0]       vr_s1, vg_s1, vb_s1, vr_s2, vg_s2, vb_s2;
	logic             found_q;
	logic [17:0]      best_dist_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [7:0]       br_q, bg_q, bb_q;
	logic [17:0]      dist_s2;
	logic [WA_W-1:0]  clr_q;
	logic             we;
	logic [WA_W-1:0]  waddr, raddr;
	logic [63:0]      wdata, rdata;
	logic             wpend_q;
	logic [24:0]      out_q;
	logic             ovld_q;

	assign d_eff = (32'(depth_q) > MAX_DEPTH) ? 3'(MAX_DEPTH) : depth_q;
	assign total = (IDX_W+1)'(1) << (3 * d_eff);

	// Candidate color levels from the scan index at the current depth.
	logic [IDX_W-1:0] cidx;
	logic [7:0]       lr, lg, lb;
	logic [IDX_W-1:0] cnt_lo;
	logic [7:0]       lmask;
	assign cnt_lo = cnt_q[IDX_W-1:0];
	assign lmask  = 8'((9'd1 << d_eff) - 9'd1);
	assign lb     = 8'(cnt_lo) & lmask;
	assign lg     = 8'(cnt_lo >> d_eff) & lmask;
	assign lr     = 8'(cnt_lo >> (2 * d_eff)) & lmask;
	assign cidx   = cnt_lo;

	// Stage 1: map word read issued, candidate value formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == nucs_pkg::ST_SCAN) && (cnt_q < total);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cidx;
		vr_s1  <= 8'(lr << (4'd8 - 4'(d_eff)));
		vg_s1  <= 8'(lg << (4'd8 - 4'(d_eff)));
		vb_s1  <= 8'(lb << (4'd8 - 4'(d_eff)));
		idx_s2 <= idx_s1;
		vr_s2  <= vr_s1;
		vg_s2  <= vg_s1;
		vb_s2  <= vb_s1;
		avail_s2 <= rdata[BIT_W'(idx_s1)];
	end

	// Scan reads follow the candidate index; the write state reads the chosen word.
	assign raddr = (state_q == nucs_pkg::ST_WRITE) ? WA_W'(best_idx_q >> nucs_pkg::WORD_AW)
		: WA_W'(cidx >> nucs_pkg::WORD_AW);

	nucs_dist u_dist (
		.clk(clk), .pr(pr_q), .pg(pg_q), .pb(pb_q),
		.vr(vr_s1), .vg(vg_s1), .vb(vb_s1), .dist_s1(dist_s2)
	);

	// Write side: clearing pass, or marking the chosen color used.
	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '1;
		if (state_q == nucs_pkg::ST_CLEAR) begin
			we = 1'b1;
		end else if (state_q == nucs_pkg::ST_WRITE && wpend_q) begin
			we    = found_q;
			waddr = WA_W'(best_idx_q >> nucs_pkg::WORD_AW);
			wdata = rdata & ~(64'd1 << BIT_W'(best_idx_q));
		end
	end

	nucs_ram #(.WIDTH(nucs_pkg::WORD_W), .DEPTH(WORDS)) u_map (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nucs_pkg::ST_CLEAR;
			depth_q <= nucs_pkg::DEPTH_RST;
			clr_q   <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			wpend_q <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				depth_q <= cfg_wdata;
			end
			case (state_q)
				nucs_pkg::ST_CLEAR: begin
					clr_q <= clr_q + WA_W'(1);
				end
				nucs_pkg::ST_IDLE: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					wpend_q <= 1'b0;
				end
				nucs_pkg::ST_SCAN: begin
					if (cnt_q < total + (IDX_W+1)'(2)) begin
						cnt_q <= cnt_q + (IDX_W+1)'(1);
					end
					if (vld_s2 && avail_s2 && (!found_q || dist_s2 < best_dist_q)) begin
						found_q <= 1'b1;
					end
				end
				nucs_pkg::ST_WRITE: begin
					wpend_q <= ~wpend_q;
					if (wpend_q) begin
						ovld_q <= 1'b1;
					end
				end
				nucs_pkg::ST_DONE: begin
					if (m_axis_tready) begin
						ovld_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pr_q <= s_axis_tdata[7:0];
			pg_q <= s_axis_tdata[15:8];
			pb_q <= s_axis_tdata[23:16];
		end
		if (state_q == nucs_pkg::ST_SCAN && vld_s2 && avail_s2
			&& (!found_q || dist_s2 < best_dist_q)) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= idx_s2;
			br_q <= vr_s2;
			bg_q <= vg_s2;
			bb_q <= vb_s2;
		end
		if (state_q == nucs_pkg::ST_WRITE && wpend_q) begin
			out_q <= found_q ? {1'b0, bb_q, bg_q, br_q} : {1'b1, 24'd0};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			nucs_pkg::ST_CLEAR: if (clr_q == WA_W'(WORDS - 1)) state_d = nucs_pkg::ST_IDLE;
			nucs_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = nucs_pkg::ST_SCAN;
			nucs_pkg::ST_SCAN:  if (cnt_q == total + (IDX_W+1)'(2)) state_d = nucs_pkg::ST_WRITE;
			nucs_pkg::ST_WRITE: if (wpend_q) state_d = nucs_pkg::ST_DONE;
			nucs_pkg::ST_DONE:  if (m_axis_tready) state_d = nucs_pkg::ST_IDLE;
			default:            state_d = nucs_pkg::ST_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == nucs_pkg::ST_IDLE);
	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = out_q[23:0];
	assign m_axis_tuser  = out_q[24];

	a_clear_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nucs_pkg::ST_CLEAR |-> !s_axis_tready) else $error("accept in clear");
	a_out_exh_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
		else $error("exhausted not black");
	a_write_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nucs_pkg::ST_WRITE && we |-> found_q) else $error("bad write");

endmodule

// ===== hdl/nucs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module nucs_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/nucs_dist.sv =====
// Distance stage: squared distance of one candidate color, registered.
module nucs_dist (
	input  logic        clk,
	input  logic [7:0]  pr,
	input  logic [7:0]  pg,
	input  logic [7:0]  pb,
	input  logic [7:0]  vr,
	input  logic [7:0]  vg,
	input  logic [7:0]  vb,
	output logic [17:0] dist_s1
);

	logic [17:0] sum;

	assign sum = 18'(nucs_pkg::sq_diff(pr, vr)) + 18'(nucs_pkg::sq_diff(pg, vg))
		+ 18'(nucs_pkg::sq_diff(pb, vb));

	always_ff @(posedge clk) begin
		dist_s1 <= sum;
	end

endmodule

// ===== verif/nearest_unused_color_search_top_tb.sv =====
// Self-checking testbench for the nearest unused color search block.
`timescale 1ns / 100ps

module nearest_unused_color_search_top_tb;

	localparam int unsigned CUBE_BITS  = 1 << 18;
	localparam int unsigned STALL_LIMIT = 800000;

	typedef struct packed {
		logic       exhausted;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} color_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // in_red[7:0], in_green[15:8], in_blue[23:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // out_red[7:0], out_green[15:8], out_blue[23:16]
	logic        m_axis_tuser;       // exhausted[0]

	// Own copy of the block state: one availability bit per cube entry.
	bit          color_free [CUBE_BITS] = '{default: 1'b1};
	logic [2:0]  cube_depth = nucs_pkg::DEPTH_RST;

	logic [23:0] pixel_q [$];
	color_t      color_q [$];
	int          fail_count = 0;
	int          quiet_cycles = 0;
	int          idle_mode;      // 0: sender 23%, receiver 75%; 1: swapped; 2: none
	bit          pixel_taken = 1'b0;

	nearest_unused_color_search_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Scan the cube in red, green, blue order; the first strictly nearer color wins.
	function automatic color_t nearest_free_color(input logic [23:0] pix);
		int unsigned d, levels, sh, idx, cand_dist, best_dist, vr, vg, vb;
		int unsigned pr, pg, pb, best_idx;
		bit          found;
		color_t      res;
		d = (cube_depth > 3'd6) ? 6 : cube_depth;
		levels = 1 << d;
		sh = 8 - d;
		pr = pix[7:0];
		pg = pix[15:8];
		pb = pix[23:16];
		found = 0;
		best_dist = 0;
		best_idx = 0;
		res = '0;
		for (int unsigned r = 0; r < levels; r++) begin
			for (int unsigned g = 0; g < levels; g++) begin
				for (int unsigned b = 0; b < levels; b++) begin
					idx = (r << (2 * d)) | (g << d) | b;
					if (color_free[idx]) begin
						vr = (r << sh) & 8'hFF;
						vg = (g << sh) & 8'hFF;
						vb = (b << sh) & 8'hFF;
						cand_dist = (pr - vr) * (pr - vr) + (pg - vg) * (pg - vg)
							+ (pb - vb) * (pb - vb);
						if (!found || cand_dist < best_dist) begin
							found = 1;
							best_dist = cand_dist;
							best_idx = idx;
							res.red = vr[7:0];
							res.green = vg[7:0];
							res.blue = vb[7:0];
						end
					end
				end
			end
		end
		if (found)
			color_free[best_idx] = 0;
		else
			res.exhausted = 1'b1;
		return res;
	endfunction

	// Accept side: track the register, predict each taken pixel, count quiet cycles.
	always @(posedge clk) begin
		pixel_taken <= s_axis_tvalid && s_axis_tready;
		if (cfg_we)
			cube_depth <= cfg_wdata;
		if (s_axis_tvalid && s_axis_tready)
			color_q.push_back(nearest_free_color(s_axis_tdata));
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		color_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata};
			if (color_q.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				fail_count++;
			end else begin
				want = color_q.pop_front();
				if (got.red !== want.red || got.green !== want.green
					|| got.blue !== want.blue || got.exhausted !== want.exhausted) begin
					$display("%0t: mismatch expected r%h g%h b%h x%b actual r%h g%h b%h x%b",
						$realtime, want.red, want.green, want.blue, want.exhausted,
						got.red, got.green, got.blue, got.exhausted);
					fail_count++;
				end
			end
		end
	end

	// Pixel driver: load the next request once the held one was taken.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || pixel_taken)) begin
			if (pixel_q.size() > 0 && !(idle_mode == 0 && $urandom_range(0, 99) < 23)
				&& !(idle_mode == 1 && $urandom_range(0, 99) < 75)) begin
				s_axis_tdata <= pixel_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: stall at random unless idle_mode is 2.
	always @(negedge clk) begin
		if (idle_mode == 0)
			m_axis_tready <= ($urandom_range(0, 99) >= 75);
		else if (idle_mode == 1)
			m_axis_tready <= ($urandom_range(0, 99) >= 23);
		else
			m_axis_tready <= 1'b1;
	end

	task automatic wait_drained();
		while (pixel_q.size() > 0 || s_axis_tvalid || color_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_depth(input logic [2:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_random(input int count);
		repeat (count)
			pixel_q.push_back({rand_chan(), rand_chan(), rand_chan()});
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_mode = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// hold off until the clearing pass after reset is done
		while (!s_axis_tready)
			@(posedge clk);

		// depth zero: one black color, then the cube is exhausted
		set_depth(3'd0);
		pixel_q.push_back(24'hFFFFFF);
		pixel_q.push_back(24'h000000);
		wait_drained();

		// depth one: the whole 2x2x2 cube, run past exhaustion
		set_depth(3'd1);
		pixel_q.push_back(24'h000000);
		pixel_q.push_back(24'hFFFFFF);
		pixel_q.push_back(24'h0000FF);
		pixel_q.push_back(24'h00FF00);
		pixel_q.push_back(24'hFF0000);
		pixel_q.push_back(24'h808080);
		pixel_q.push_back(24'h7F7F7F);
		pixel_q.push_back(24'h404040);
		pixel_q.push_back(24'hFF00FF);
		wait_drained();

		// out-of-range depth saturates to six; map is reused without clearing
		set_depth(3'd7);
		pixel_q.push_back(24'h000000);
		wait_drained();
		set_depth(3'd6);
		pixel_q.push_back(24'hFFFFFF);
		wait_drained();

		set_depth(3'd2);
		pixel_q.push_back(24'h000000);
		pixel_q.push_back(24'h000000);
		pixel_q.push_back(24'hFFFFFF);
		pixel_q.push_back(24'h202020);
		pixel_q.push_back(24'h603FA0);
		idle_mode = 1;
		push_random(70);
		wait_drained();

		set_depth(3'd3);
		push_random(50);
		wait_drained();

		idle_mode = 2;
		set_depth(3'd4);
		push_random(8);
		wait_drained();
		set_depth(3'd5);
		push_random(2);
		wait_drained();

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
